// ===== rtl/assert_macros.svh =====
// Assertion macros for the piecewise-linear lookup block.
// Self-contained; taken in by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden state");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/pwl_pkg.sv =====
// Package for the piecewise-linear lookup block: codes, states, sizes.
// No dependencies.
`default_nettype none
package pwl_pkg;
    localparam int DEPTH_DEF     = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_FORWARD = 2'd2;
    localparam logic [1:0] OP_INVERSE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS,
        S_EP_RD,
        S_EP_CMP,
        S_SEG_RD,
        S_SEG_CMP,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend_hi;
        logic [31:0] dividend_lo;
        logic [31:0] divisor;
    } div_req_t;
endpackage
`default_nettype wire

// ===== rtl/pwl_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/pwl_div.sv =====
// Restoring divider: 64-bit unsigned dividend by 32-bit divisor, one bit a cycle.
// Depends on pwl_pkg.
`default_nettype none
module pwl_div
    import pwl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output logic          done,
    output logic [31:0]   quot
);
    logic [31:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[63]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = {req.dividend_hi, req.dividend_lo};
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[33])
            begin
                rem_next = shifted[31:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                dvd_next = {dvd_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    // Take the last quotient bit in the same cycle as the done strobe.
    assign quot = dvd_next[31:0];
endmodule
`default_nettype wire

// ===== rtl/piecewise_linear_lookup_inverse.sv =====
// Piecewise-linear lookup with inverse: sequencer, breakpoint RAMs, divider.
// Load and evaluate binary-search the table, in 7 search steps at most for 64 points;
// evaluate may interpolate in the bit-serial divider. One transaction at a time:
// busy falls as done rises, so the next start is taken at the edge ending the
// strobe. Reset (rst_n, async) empties the table; no clearing pass. The receiver
// cannot stall: results stand for one cycle.
`default_nettype none
`include "assert_macros.svh"
module piecewise_linear_lookup_inverse
    import pwl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] query,
    output logic                    done,
    output logic signed [31:0]      answer,
    output logic [1:0]              status
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, len_reg, len_next, mid;
    logic [CW-1:0] k_reg, k_next, k_dec;
    logic [1:0]  op_reg, op_next;
    logic signed [31:0] px_reg, py_reg, q_reg;
    logic signed [31:0] ki_reg, kj_reg, vi_reg, vj_reg;
    logic signed [31:0] ki_next, kj_next, vi_next, vj_next;
    logic signed [31:0] ans_reg, ans_next;
    logic [1:0]  st_reg, st_next;
    logic        done_reg, done_next;
    logic        ep_phase_reg, ep_phase_next;
    logic        neg_reg, neg_next;
    logic [63:0] prod_reg, prod_next;
    logic [32:0] span_reg, span_next;

    logic [AW-1:0] addr;
    logic          we;
    logic [31:0]   wx, wy, rx, ry, rkey, rval;
    logic          inv;
    div_req_t      dreq;
    logic          ddone;
    logic [31:0]   dquot;
    logic [32:0]   off, dv, mag;

    pwl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_x (
        .clk(clk), .we(we), .addr(addr), .wdata(wx), .rdata(rx));
    pwl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_y (
        .clk(clk), .we(we), .addr(addr), .wdata(wy), .rdata(ry));
    pwl_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

    assign inv   = (op_reg == OP_INVERSE);
    assign rkey  = inv ? ry : rx;
    assign rval  = inv ? rx : ry;
    assign mid   = lo_reg + (len_reg >> 1);
    assign k_dec = k_reg - CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        len_next      = len_reg;
        k_next        = k_reg;
        op_next       = op_reg;
        ki_next       = ki_reg;
        kj_next       = kj_reg;
        vi_next       = vi_reg;
        vj_next       = vj_reg;
        ans_next      = ans_reg;
        st_next       = st_reg;
        done_next     = 1'b0;
        ep_phase_next = ep_phase_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        span_next     = span_reg;
        addr          = k_reg[AW-1:0];
        we            = 1'b0;
        wx            = rx;
        wy            = ry;
        off           = {q_reg[31], q_reg} - {ki_reg[31], ki_reg};
        dv            = {vj_reg[31], vj_reg} - {vi_reg[31], vi_reg};
        mag           = dv[32] ? (33'd0 - dv) : dv;
        dreq.start       = 1'b0;
        dreq.dividend_hi = prod_reg[63:32];
        dreq.dividend_lo = prod_reg[31:0];
        dreq.divisor     = span_reg[31:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = operation;
                    ans_next = '0;
                    st_next  = ST_OK;
                    lo_next  = '0;
                    len_next = count_reg;
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        OP_LOAD:
                        begin
                            if (count_reg >= FULL)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                st_next    = ST_FEW;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ep_phase_next = 1'b0;
                                k_next        = '0;
                                state_next    = S_EP_RD;
                            end
                        end
                    endcase
                end
            end
            S_EP_RD:
            begin
                // Fetch first then last point.
                state_next = S_EP_CMP;
            end
            S_EP_CMP:
            begin
                if (!ep_phase_reg)
                begin
                    if (q_reg <= $signed(rkey))
                    begin
                        ans_next   = rval;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ep_phase_next = 1'b1;
                        k_next        = count_reg - CW'(1);
                        state_next    = S_EP_RD;
                    end
                end
                else if (q_reg >= $signed(rkey))
                begin
                    ans_next   = rval;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (len_reg == '0)
                begin
                    if (op_reg == OP_LOAD)
                    begin
                        k_next     = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        // Clamp the segment index to 1..count-1.
                        if (lo_reg == '0)
                            k_next = CW'(1);
                        else if (lo_reg > count_reg - CW'(1))
                            k_next = count_reg - CW'(1);
                        else
                            k_next = lo_reg;
                        ep_phase_next = 1'b0;
                        state_next    = S_SEG_RD;
                    end
                end
                else
                begin
                    addr       = mid[AW-1:0];
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                addr = mid[AW-1:0];
                if (((op_reg == OP_LOAD) ? px_reg : q_reg) < $signed(rkey))
                begin
                    len_next = len_reg >> 1;
                end
                else
                begin
                    lo_next  = mid + CW'(1);
                    len_next = len_reg - (len_reg >> 1) - CW'(1);
                end
                state_next = S_SRCH_RD;
            end
            S_SHIFT_RD:
            begin
                if (k_reg == lo_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    addr       = k_dec[AW-1:0];
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                we         = 1'b1;
                k_next     = k_dec;
                state_next = S_SHIFT_RD;
            end
            S_INS:
            begin
                we         = 1'b1;
                wx         = px_reg;
                wy         = py_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_SEG_RD:
            begin
                addr       = ep_phase_reg ? k_reg[AW-1:0] : k_dec[AW-1:0];
                state_next = S_SEG_CMP;
            end
            S_SEG_CMP:
            begin
                if (!ep_phase_reg)
                begin
                    ki_next       = rkey;
                    vi_next       = rval;
                    ep_phase_next = 1'b1;
                    state_next    = S_SEG_RD;
                end
                else
                begin
                    kj_next = rkey;
                    vj_next = rval;
                    if (q_reg < ki_reg || $signed(rkey) <= ki_reg)
                    begin
                        ans_next   = vi_reg;
                        state_next = S_DONE;
                    end
                    else if (q_reg >= $signed(rkey))
                    begin
                        ans_next   = rval;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        span_next  = {rkey[31], rkey} - {ki_reg[31], ki_reg};
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = {32'd0, off[31:0]} * {31'd0, mag};
                neg_next   = dv[32];
                state_next = S_DIV;
                k_next     = '0;
            end
            S_DIV:
            begin
                if (k_reg == '0)
                begin
                    dreq.start = 1'b1;
                    k_next     = CW'(1);
                end
                else if (ddone)
                begin
                    ans_next   = neg_reg ? (vi_reg - $signed(dquot)) : (vi_reg + $signed(dquot));
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        len_reg      <= len_next;
        k_reg        <= k_next;
        op_reg       <= op_next;
        ki_reg       <= ki_next;
        kj_reg       <= kj_next;
        vi_reg       <= vi_next;
        vj_reg       <= vj_next;
        ans_reg      <= ans_next;
        st_reg       <= st_next;
        ep_phase_reg <= ep_phase_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        span_reg     <= span_next;
        if (state_reg == S_IDLE && start)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            q_reg  <= query;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign answer = done_reg ? ans_reg : '0;
    assign status = done_reg ? st_reg : ST_OK;

    `ASSERT_IMPL(a_count_bound, clk, rst_n, count_reg <= FULL)
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done |-> !busy)
    `ASSERT_NEVER(a_full_load, clk, rst_n, done && status == ST_FULL && count_reg != FULL)
endmodule
`default_nettype wire
